>>> design/linear_recurrence_matrix_power_mod_assert.svh
// Assertion macros for the matrix power block.
// Included by the RTL modules that carry assertions; no other dependencies.
`ifndef LINEAR_RECURRENCE_MATRIX_POWER_MOD_ASSERT_SVH
`define LINEAR_RECURRENCE_MATRIX_POWER_MOD_ASSERT_SVH
`ifndef SYNTHESIS
`define LRMP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LRMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LRMP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LRMP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/lrmp_pkg.sv
// Shared types and constants for the matrix power block.
// No dependencies.
`default_nettype none
package lrmp_pkg;
   localparam logic [29:0] PRIME_MOD = 30'd1000000007;
   localparam int VAL_W = 30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_MUL_ACC,
      ST_MUL_SQR,
      ST_NEXT_BIT,
      ST_DONE
   } ctrl_state_type;

   // product select: acc = acc*base, or base = base*base
   typedef enum logic {
      OP_ACC,
      OP_SQR
   } mul_op_type;

   typedef struct packed {
      logic       init;      // load identity and companion
      logic       mul_start; // begin one matrix product
      mul_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;        // product finished and written back
   } dp_status_type;

   // a < 2^30 + 2^30 style reduction: value known below 2*PRIME_MOD
   function automatic logic [29:0] mod_fold(input logic [30:0] v);
      logic [30:0] d;
      d = v - {1'b0, PRIME_MOD};
      mod_fold = d[30] ? v[29:0] : d[29:0];
   endfunction
endpackage
`default_nettype wire

>>> design/linear_recurrence_matrix_power_mod.sv
// Top level: f(n) of the order-ORDER sum recurrence mod 1000000007 by matrix power.
// Uses lrmp_pkg, lrmp_ctrl, lrmp_datapath.
//  channel   ports                               handshake
//  request   req_term_index[EXP_BITS-1:0]        start & !busy
//  result    rsp_term_value[29:0]                rsp_valid, one cycle
// One request at a time. Each of EXP_BITS bits takes a squaring and, for a set bit,
// one more product; each product streams ORDER^3 operations through a read stage and
// the 5-stage modular multiplier. Busy drops the cycle after the result strobe.
// Synchronous reset returns to idle. The receiver cannot stall.
`default_nettype none
module linear_recurrence_matrix_power_mod
   import lrmp_pkg::*;
#(
   parameter int ORDER    = 6,
   parameter int EXP_BITS = 60
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [EXP_BITS-1:0] req_term_index,
   output logic                     rsp_valid,
   output logic [VAL_W-1:0]         rsp_term_value
);
   dp_cmd_type    cmd;
   dp_status_type status;

   lrmp_ctrl #(.EXP_BITS(EXP_BITS)) u_ctrl (
      .clock, .reset, .start, .req_term_index, .busy, .rsp_valid, .cmd, .status
   );

   lrmp_datapath #(.ORDER(ORDER)) u_dp (
      .clock, .reset, .cmd, .status, .term_value(rsp_term_value)
   );
endmodule
`default_nettype wire

>>> design/lrmp_modmul.sv
// Pipelined modular multiplier: a*b mod 1000000007, Barrett style.
// Uses lrmp_pkg. One product per cycle.
`default_nettype none
module lrmp_modmul
   import lrmp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [VAL_W-1:0] a,
   input  wire logic [VAL_W-1:0] b,
   output logic                  out_valid,
   output logic [VAL_W-1:0]      prod
);
   // mu = floor(2^90 / p), fits in 61 bits
   localparam logic [60:0] MU = 61'((128'd1 << 90) / 128'd1000000007);

   logic [4:0]  vld_ff;
   logic [59:0] x_ff, x2_ff, x3_ff, x4_ff;
   logic [30:0] q_ff;
   logic [59:0] qp_ff;
   logic [31:0] r_ff;
   logic [90:0] q_full;
   logic [31:0] r_in;
   logic [31:0] r1;

   // q_full = (x>>29) * MU >> 61, split as 16x61 and 15x61 products summed over a stage
   logic [91:0] pl_ff, ph_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[3:0], in_valid};
   end

   always_ff @(posedge clock) begin
      x_ff   <= 60'(a) * 60'(b);
      pl_ff  <= 92'(x_ff[44:29]) * 92'(MU);
      ph_ff  <= 92'(x_ff[59:45]) * 92'(MU);
      x2_ff  <= x_ff;
      q_ff   <= 31'(q_full >> 61);
      x3_ff  <= x2_ff;
      qp_ff  <= 60'(q_ff) * 60'(PRIME_MOD);
      x4_ff  <= x3_ff;
      r_ff   <= r_in;
   end

   always_comb begin
      q_full = 91'(pl_ff) + 91'({ph_ff, 16'd0});
      r_in   = 32'(x4_ff - qp_ff);
      // remainder below 3p: two folds
      r1     = (r_ff >= 32'({PRIME_MOD, 1'b0})) ? r_ff - 32'({PRIME_MOD, 1'b0})
             : (r_ff >= 32'(PRIME_MOD)) ? r_ff - 32'(PRIME_MOD) : r_ff;
   end

   assign out_valid = vld_ff[4];
   assign prod      = r1[29:0];
endmodule
`default_nettype wire

>>> design/lrmp_datapath.sv
// Datapath: acc, base and product matrices in one banked memory, one shared modular
// multiplier, accumulation. Uses lrmp_pkg and lrmp_modmul.
`default_nettype none
`include "linear_recurrence_matrix_power_mod_assert.svh"
module lrmp_datapath
   import lrmp_pkg::*;
#(
   parameter int ORDER = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   output logic [VAL_W-1:0]   term_value
);
   localparam int IW = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int NE = ORDER * ORDER;
   localparam int EW = $clog2(NE + 1);
   localparam int AW = $clog2(3 * NE);

   // three banks; acc, base and the product target rotate between them
   logic [VAL_W-1:0] mat_mem [3 * NE];
   logic [1:0]       acc_sel_ff, base_sel_ff, res_sel;
   // banks not yet written: identity and companion implied after init
   logic             acc_id_ff, base_cp_ff;
   logic [VAL_W-1:0] tail_ff, term_ff;

   // issue side: r, c, k counters
   logic          iss_ff, iss_in;
   logic [IW-1:0] ir_ff, ic_ff, ik_ff, ir_in, ic_in, ik_in;
   mul_op_type    op_ff;
   logic          rd_vld_ff;
   // return side
   logic [IW-1:0] rk_ff, rr_ff, rc_ff;
   logic [EW-1:0] done_cnt_ff;
   logic [VAL_W-1:0] sum_ff;
   logic          wb_ff;

   logic [VAL_W-1:0] ma_ff, mb_ff, prod, wr_data;
   logic [AW-1:0] addr_a, addr_b, wr_addr;
   logic mvalid;

   function automatic logic [AW-1:0] mem_addr(input logic [1:0] bank,
                                              input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
      mem_addr = AW'(bank) * AW'(NE) + AW'(r) * AW'(ORDER) + AW'(c);
   endfunction

   function automatic logic [VAL_W-1:0] ident_entry(input logic [IW-1:0] r,
                                                    input logic [IW-1:0] c);
      ident_entry = (r == c) ? VAL_W'(1) : '0;
   endfunction

   function automatic logic [VAL_W-1:0] comp_entry(input logic [IW-1:0] r,
                                                   input logic [IW-1:0] c);
      comp_entry = ((c == r + 1'b1) || (r == IW'(ORDER - 1))) ? VAL_W'(1) : '0;
   endfunction

   always_comb begin
      res_sel = 2'd3 - acc_sel_ff - base_sel_ff;
      addr_a  = mem_addr((op_ff == OP_ACC) ? acc_sel_ff : base_sel_ff, ir_ff, ik_ff);
      addr_b  = mem_addr(base_sel_ff, ik_ff, ic_ff);
      wr_addr = mem_addr(res_sel, rr_ff, rc_ff);
      wr_data = (rk_ff == '0) ? prod : mod_fold({1'b0, sum_ff} + {1'b0, prod});
      iss_in = iss_ff; ir_in = ir_ff; ic_in = ic_ff; ik_in = ik_ff;
      if (cmd.mul_start) begin
         iss_in = 1'b1; ir_in = '0; ic_in = '0; ik_in = '0;
      end else if (iss_ff) begin
         if (ik_ff == IW'(ORDER - 1)) begin
            ik_in = '0;
            if (ic_ff == IW'(ORDER - 1)) begin
               ic_in = '0;
               if (ir_ff == IW'(ORDER - 1)) iss_in = 1'b0;
               else ir_in = ir_ff + 1'b1;
            end else ic_in = ic_ff + 1'b1;
         end else ik_in = ik_ff + 1'b1;
      end
   end

   lrmp_modmul u_mul (
      .clock, .reset, .in_valid(rd_vld_ff), .a(ma_ff), .b(mb_ff),
      .out_valid(mvalid), .prod
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= 1'b0; rd_vld_ff <= 1'b0; wb_ff <= 1'b0; done_cnt_ff <= '0;
         rk_ff <= '0; rr_ff <= '0; rc_ff <= '0;
         acc_sel_ff <= 2'd0; base_sel_ff <= 2'd1;
         acc_id_ff <= 1'b1; base_cp_ff <= 1'b1; term_ff <= VAL_W'(1);
      end else begin
         iss_ff <= iss_in; rd_vld_ff <= iss_ff; wb_ff <= 1'b0;
         if (cmd.mul_start) begin
            done_cnt_ff <= '0; rk_ff <= '0; rr_ff <= '0; rc_ff <= '0;
         end else if (mvalid) begin
            if (rk_ff == IW'(ORDER - 1)) begin
               rk_ff <= '0;
               done_cnt_ff <= done_cnt_ff + 1'b1;
               if (done_cnt_ff == EW'(NE - 1)) wb_ff <= 1'b1;
               if (rc_ff == IW'(ORDER - 1)) begin
                  rc_ff <= '0; rr_ff <= rr_ff + 1'b1;
               end else rc_ff <= rc_ff + 1'b1;
            end else rk_ff <= rk_ff + 1'b1;
         end
         if (cmd.init) begin
            acc_sel_ff <= 2'd0; base_sel_ff <= 2'd1;
            acc_id_ff <= 1'b1; base_cp_ff <= 1'b1; term_ff <= VAL_W'(1);
         end else if (wb_ff) begin
            // finished product bank takes over the role of its destination
            if (op_ff == OP_ACC) begin
               acc_sel_ff <= res_sel; acc_id_ff <= 1'b0; term_ff <= tail_ff;
            end else begin
               base_sel_ff <= res_sel; base_cp_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ir_ff <= ir_in; ic_ff <= ic_in; ik_ff <= ik_in;
      if (cmd.mul_start) op_ff <= cmd.op;
      if (op_ff == OP_ACC && acc_id_ff)      ma_ff <= ident_entry(ir_ff, ik_ff);
      else if (op_ff == OP_SQR && base_cp_ff) ma_ff <= comp_entry(ir_ff, ik_ff);
      else                                    ma_ff <= mat_mem[addr_a];
      mb_ff <= base_cp_ff ? comp_entry(ik_ff, ic_ff) : mat_mem[addr_b];
      if (mvalid) begin
         sum_ff <= wr_data;
         if (rk_ff == IW'(ORDER - 1)) begin
            mat_mem[wr_addr] <= wr_data;
            if (rr_ff == IW'(ORDER - 1) && rc_ff == IW'(ORDER - 1)) tail_ff <= wr_data;
         end
      end
   end

   assign status.mul_done = wb_ff;
   assign term_value = term_ff;

   `LRMP_ASSERT_NEXT(a_start_issues, clock, reset, cmd.mul_start, iss_ff)
   `LRMP_ASSERT_IMPL(a_no_start_busy, clock, reset, cmd.mul_start, !iss_ff && !rd_vld_ff && !mvalid)
   `LRMP_ASSERT_IMPL(a_wb_after_last, clock, reset, wb_ff, done_cnt_ff == EW'(NE))
endmodule
`default_nettype wire

>>> design/lrmp_ctrl.sv
// Controller: walks exponent bits, sequences matrix products, handshake.
// Uses lrmp_pkg.
`default_nettype none
`include "linear_recurrence_matrix_power_mod_assert.svh"
module lrmp_ctrl
   import lrmp_pkg::*;
#(
   parameter int EXP_BITS = 60
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [EXP_BITS-1:0] req_term_index,
   output logic                     busy,
   output logic                     rsp_valid,
   output dp_cmd_type               cmd,
   input  wire dp_status_type       status
);
   localparam int BW = $clog2(EXP_BITS + 1);

   ctrl_state_type state_ff, state_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic issued_ff, issued_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; bit_ff <= '0; issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in; bit_ff <= bit_in; issued_ff <= issued_in;
      end
      exp_ff <= exp_in;
   end

   always_comb begin
      state_in = state_ff; exp_in = exp_ff; bit_in = bit_ff; issued_in = issued_ff;
      cmd = '{init: 1'b0, mul_start: 1'b0, op: OP_ACC};
      busy = 1'b1; rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               exp_in = req_term_index; bit_in = '0; state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1; issued_in = 1'b0; state_in = ST_MUL_ACC;
         end
         ST_MUL_ACC: begin
            if (!exp_ff[0]) state_in = ST_MUL_SQR;
            else if (!issued_ff) begin
               cmd.mul_start = 1'b1; cmd.op = OP_ACC; issued_in = 1'b1;
            end else if (status.mul_done) begin
               issued_in = 1'b0; state_in = ST_MUL_SQR;
            end
         end
         ST_MUL_SQR: begin
            if (!issued_ff) begin
               cmd.mul_start = 1'b1; cmd.op = OP_SQR; issued_in = 1'b1;
            end else if (status.mul_done) begin
               issued_in = 1'b0; state_in = ST_NEXT_BIT;
            end
         end
         ST_NEXT_BIT: begin
            exp_in = exp_ff >> 1; bit_in = bit_ff + 1'b1;
            state_in = (bit_ff == BW'(EXP_BITS - 1)) ? ST_DONE : ST_MUL_ACC;
         end
         ST_DONE: begin
            rsp_valid = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `LRMP_ASSERT_NEXT(a_accept_init, clock, reset, start && !busy, state_ff == ST_INIT)
   `LRMP_ASSERT_IMPL(a_rsp_one_cycle, clock, reset, rsp_valid, !$past(rsp_valid))
   `LRMP_ASSERT_IMPL(a_start_idle_dp, clock, reset, cmd.mul_start, !status.mul_done)
endmodule
`default_nettype wire
